/* rtl/macd_pkg.sv */
// ---------------------------------------------------------------------------
// macd_pkg
// shared types and constants of the macd indicator engine
// ---------------------------------------------------------------------------
`default_nettype none

package macd_pkg;

   // field and datapath widths
   localparam int PRODUCT_W = 16;
   localparam int SIDE_W    = 2;
   localparam int PRICE_W   = 32;
   localparam int WIN_W     = 7;
   localparam int COUNT_W   = 16;
   localparam int SUM_W     = 48;
   localparam int ACC_W     = 38;
   localparam int NUM_W     = 40;
   localparam int PROD_W    = 39;
   localparam int MACD_W    = 33;
   localparam int DIV_W     = 48;
   localparam int DSR_W     = 16;
   localparam int DCNT_W    = 6;
   localparam int SEEN_W    = 7;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [SEEN_W-1:0]  SEEN_MAX   = 7'd127;
   localparam logic [WIN_W-1:0]   WIN_MIN    = 7'd2;
   localparam int                 WINDOW_MAX = 64;

   // register indexes
   localparam logic [1:0] REG_PRODUCT = 2'd0;
   localparam logic [1:0] REG_SIDE    = 2'd1;
   localparam logic [1:0] REG_LONG    = 2'd2;
   localparam logic [1:0] REG_SHORT   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_SWEEP,
      ST_SMAL_GO,
      ST_SMAL_WAIT,
      ST_SMAS_GO,
      ST_SMAS_WAIT,
      ST_MUL,
      ST_EMAL_GO,
      ST_EMAL_WAIT,
      ST_EMAS_GO,
      ST_EMAS_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      DSEL_AVG,
      DSEL_SMA_L,
      DSEL_SMA_S,
      DSEL_EMA_L,
      DSEL_EMA_S
   } div_sel_type;

   typedef struct packed {
      logic        acc_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        sweep_clr;
      logic        sweep_step;
      logic        mul_en;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sweep_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/macd_div.sv */
// ---------------------------------------------------------------------------
// macd_div
// radix-2 restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module macd_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [macd_pkg::DIV_W-1:0]  dividend,
   input  wire logic [macd_pkg::DSR_W-1:0]  divisor,
   output logic                             done,
   output logic [macd_pkg::DIV_W-1:0]       quotient
);

   logic [macd_pkg::DIV_W-1:0]  q_ff, q_in;
   logic [macd_pkg::DSR_W-1:0]  rem_ff, rem_in;
   logic [macd_pkg::DSR_W-1:0]  dsr_ff, dsr_in;
   logic [macd_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [macd_pkg::DSR_W:0]    trial;
   logic                        fits;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff, q_ff[macd_pkg::DIV_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = macd_pkg::DCNT_W'(macd_pkg::DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[macd_pkg::DIV_W-2:0], fits};
         rem_in = fits ? macd_pkg::DSR_W'(trial - {1'b0, dsr_ff})
                       : trial[macd_pkg::DSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

/* rtl/macd_dp.sv */
// ---------------------------------------------------------------------------
// macd_dp
// period accumulator, average history memory, window sums, ema arithmetic
// ---------------------------------------------------------------------------
`default_nettype none

module macd_dp #(
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire macd_pkg::cmd_type               cmd,
   output macd_pkg::status_type                 status,
   input  wire logic [macd_pkg::PRODUCT_W-1:0]  product_select,
   input  wire logic [macd_pkg::SIDE_W-1:0]     side_select,
   input  wire logic [macd_pkg::WIN_W-1:0]      long_period,
   input  wire logic [macd_pkg::WIN_W-1:0]      short_period,
   input  wire logic [macd_pkg::PRODUCT_W-1:0]  item_product,
   input  wire logic [macd_pkg::SIDE_W-1:0]     item_side,
   input  wire logic [macd_pkg::PRICE_W-1:0]    price,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [macd_pkg::MACD_W-1:0]   rsp_macd,
   output logic [macd_pkg::PRICE_W-1:0]         rsp_ema_long,
   output logic [macd_pkg::PRICE_W-1:0]         rsp_ema_short,
   output logic                                 rsp_ready_res
);

   localparam int PW  = $clog2(HISTORY_DEPTH);
   localparam int IW  = (PW + 1 > macd_pkg::WIN_W) ? PW + 1 : macd_pkg::WIN_W;
   localparam int LIM = (HISTORY_DEPTH < macd_pkg::WINDOW_MAX) ?
                        HISTORY_DEPTH : macd_pkg::WINDOW_MAX;

   logic [macd_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [macd_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [PW-1:0]                 ptr_ff, ptr_in;
   logic [macd_pkg::SEEN_W-1:0]   seen_ff, seen_in;
   logic [macd_pkg::PRICE_W-1:0]  avg_ff, avg_in;
   logic [macd_pkg::PRICE_W-1:0]  smal_ff, smal_in, smas_ff, smas_in;
   logic [macd_pkg::PRICE_W-1:0]  emal_ff, emal_in, emas_ff, emas_in;
   logic [macd_pkg::NUM_W-1:0]    numl_ff, numl_in, nums_ff, nums_in;
   logic [macd_pkg::ACC_W-1:0]    accl_ff, accl_in, accs_ff, accs_in;
   logic [macd_pkg::WIN_W-1:0]    k_ff, k_in, kd_ff, kd_in;
   logic                          rdv_ff, rdv_in;
   macd_pkg::div_sel_type         sel_ff, sel_in;
   logic                          ov_ff, ov_in;
   logic signed [macd_pkg::MACD_W-1:0] omacd_ff, omacd_in;
   logic [macd_pkg::PRICE_W-1:0]  oel_ff, oel_in, oes_ff, oes_in;
   logic                          ordy_ff, ordy_in;

   logic [macd_pkg::PRICE_W-1:0]  hist_mem [HISTORY_DEPTH];
   logic [macd_pkg::PRICE_W-1:0]  mem_q_ff;

   logic [macd_pkg::WIN_W-1:0]    nl, ns, kmax;
   logic                          match;
   logic                          rd_en;
   logic [IW-1:0]                 ptr_w, k_w, diff_w;
   logic [PW-1:0]                 rd_addr;
   logic                          div_done;
   logic [macd_pkg::DIV_W-1:0]    div_q;
   logic [macd_pkg::DIV_W-1:0]    div_a;
   logic [macd_pkg::DSR_W-1:0]    div_b;
   logic [macd_pkg::PROD_W-1:0]   prodl, prods;
   logic                          out_free;

   // window length clamp
   function automatic logic [macd_pkg::WIN_W-1:0] clamp_win(
      input logic [macd_pkg::WIN_W-1:0] n);
      logic [macd_pkg::WIN_W-1:0] r;
      r = n;
      if (n < macd_pkg::WIN_MIN) r = macd_pkg::WIN_MIN;
      else if (n > macd_pkg::WIN_W'(LIM)) r = macd_pkg::WIN_W'(LIM);
      return r;
   endfunction

   assign nl   = clamp_win(long_period);
   assign ns   = clamp_win(short_period);
   assign kmax = (nl > ns) ? nl : ns;
   assign match = (item_product == product_select) && (item_side == side_select) &&
                  (count_ff < macd_pkg::COUNT_MAX);

   // history address of the entry k periods back
   always_comb begin
      ptr_w   = IW'(ptr_ff);
      k_w     = IW'(k_ff);
      diff_w  = (ptr_w >= k_w) ? ptr_w - k_w : ptr_w + IW'(HISTORY_DEPTH) - k_w;
      rd_addr = diff_w[PW-1:0];
      rd_en   = cmd.sweep_step && (k_ff <= kmax);
   end

   // divider operand select
   always_comb begin
      div_a = '0;
      div_b = '0;
      case (cmd.div_sel)
         macd_pkg::DSEL_AVG: begin
            div_a = sum_ff;
            div_b = count_ff;
         end
         macd_pkg::DSEL_SMA_L: begin
            div_a = macd_pkg::DIV_W'(accl_ff);
            div_b = macd_pkg::DSR_W'(nl);
         end
         macd_pkg::DSEL_SMA_S: begin
            div_a = macd_pkg::DIV_W'(accs_ff);
            div_b = macd_pkg::DSR_W'(ns);
         end
         macd_pkg::DSEL_EMA_L: begin
            div_a = macd_pkg::DIV_W'(numl_ff);
            div_b = macd_pkg::DSR_W'(nl) + 1'b1;
         end
         macd_pkg::DSEL_EMA_S: begin
            div_a = macd_pkg::DIV_W'(nums_ff);
            div_b = macd_pkg::DSR_W'(ns) + 1'b1;
         end
         default: begin
            div_a = '0;
            div_b = '0;
         end
      endcase
   end

   macd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign prodl    = macd_pkg::PROD_W'(nl - 1'b1) * macd_pkg::PROD_W'(smal_ff);
   assign prods    = macd_pkg::PROD_W'(ns - 1'b1) * macd_pkg::PROD_W'(smas_ff);
   assign out_free = !ov_ff || !rsp_stall;

   // next values of datapath registers
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      seen_in  = seen_ff;
      avg_in   = avg_ff;
      smal_in  = smal_ff;
      smas_in  = smas_ff;
      emal_in  = emal_ff;
      emas_in  = emas_ff;
      numl_in  = numl_ff;
      nums_in  = nums_ff;
      accl_in  = accl_ff;
      accs_in  = accs_ff;
      k_in     = k_ff;
      kd_in    = kd_ff;
      rdv_in   = rd_en;
      sel_in   = cmd.div_start ? cmd.div_sel : sel_ff;
      ov_in    = ov_ff && rsp_stall;
      omacd_in = omacd_ff;
      oel_in   = oel_ff;
      oes_in   = oes_ff;
      ordy_in  = ordy_ff;

      // order accumulation
      if (cmd.acc_en && match) begin
         sum_in   = sum_ff + macd_pkg::SUM_W'(price);
         count_in = count_ff + 1'b1;
      end

      // window sweep over the history
      if (cmd.sweep_clr) begin
         k_in    = macd_pkg::WIN_W'(1);
         accl_in = '0;
         accs_in = '0;
         rdv_in  = 1'b0;
      end else begin
         if (rd_en) begin
            k_in  = k_ff + 1'b1;
            kd_in = k_ff;
         end
         if (rdv_ff && (kd_ff <= seen_ff)) begin
            if (kd_ff <= nl) accl_in = accl_ff + macd_pkg::ACC_W'(mem_q_ff);
            if (kd_ff <= ns) accs_in = accs_ff + macd_pkg::ACC_W'(mem_q_ff);
         end
      end

      // quotient capture
      if (div_done) begin
         case (sel_ff)
            macd_pkg::DSEL_AVG:   avg_in  = (count_ff == '0) ? '0 : div_q[macd_pkg::PRICE_W-1:0];
            macd_pkg::DSEL_SMA_L: smal_in = div_q[macd_pkg::PRICE_W-1:0];
            macd_pkg::DSEL_SMA_S: smas_in = div_q[macd_pkg::PRICE_W-1:0];
            macd_pkg::DSEL_EMA_L: emal_in = div_q[macd_pkg::PRICE_W-1:0];
            macd_pkg::DSEL_EMA_S: emas_in = div_q[macd_pkg::PRICE_W-1:0];
            default:              avg_in  = avg_ff;
         endcase
      end

      // ema numerators with half-divisor rounding term
      if (cmd.mul_en) begin
         numl_in = (macd_pkg::NUM_W'(avg_ff) << 1) + macd_pkg::NUM_W'(prodl) +
                   macd_pkg::NUM_W'((nl + 1'b1) >> 1);
         nums_in = (macd_pkg::NUM_W'(avg_ff) << 1) + macd_pkg::NUM_W'(prods) +
                   macd_pkg::NUM_W'((ns + 1'b1) >> 1);
      end

      // result word and period close
      if (cmd.emit) begin
         ov_in    = 1'b1;
         omacd_in = $signed({1'b0, emas_ff}) - $signed({1'b0, emal_ff});
         oel_in   = emal_ff;
         oes_in   = emas_ff;
         ordy_in  = seen_ff >= nl;
         ptr_in   = (ptr_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         seen_in  = (seen_ff < macd_pkg::SEEN_MAX) ? seen_ff + 1'b1 : seen_ff;
         sum_in   = '0;
         count_in = '0;
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (cmd.emit) hist_mem[ptr_ff] <= avg_ff;
      if (rd_en) mem_q_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      avg_ff   <= avg_in;
      smal_ff  <= smal_in;
      smas_ff  <= smas_in;
      emal_ff  <= emal_in;
      emas_ff  <= emas_in;
      numl_ff  <= numl_in;
      nums_ff  <= nums_in;
      accl_ff  <= accl_in;
      accs_ff  <= accs_in;
      k_ff     <= k_in;
      kd_ff    <= kd_in;
      sel_ff   <= sel_in;
      omacd_ff <= omacd_in;
      oel_ff   <= oel_in;
      oes_ff   <= oes_in;
      ordy_ff  <= ordy_in;
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         seen_ff  <= '0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         seen_ff  <= seen_in;
         rdv_ff   <= rdv_in;
         ov_ff    <= ov_in;
      end
   end

   assign status.div_done   = div_done;
   assign status.sweep_done = (k_ff > kmax) && !rdv_ff;
   assign status.out_free   = out_free;

   assign rsp_valid     = ov_ff;
   assign rsp_macd      = omacd_ff;
   assign rsp_ema_long  = oel_ff;
   assign rsp_ema_short = oes_ff;
   assign rsp_ready_res = ordy_ff;

endmodule

`default_nettype wire

/* rtl/macd_ctrl.sv */
// ---------------------------------------------------------------------------
// macd_ctrl
// sequencer for the period close: average, window sums, smas, emas, emit
// ---------------------------------------------------------------------------
`default_nettype none

module macd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last_of_period,
   output logic                      req_stall,
   input  wire macd_pkg::status_type status,
   output macd_pkg::cmd_type         cmd
);

   macd_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         macd_pkg::ST_IDLE:      if (req_valid && req_last_of_period) state_in = macd_pkg::ST_AVG_GO;
         macd_pkg::ST_AVG_GO:    state_in = macd_pkg::ST_AVG_WAIT;
         macd_pkg::ST_AVG_WAIT:  if (status.div_done) state_in = macd_pkg::ST_SWEEP;
         macd_pkg::ST_SWEEP:     if (status.sweep_done) state_in = macd_pkg::ST_SMAL_GO;
         macd_pkg::ST_SMAL_GO:   state_in = macd_pkg::ST_SMAL_WAIT;
         macd_pkg::ST_SMAL_WAIT: if (status.div_done) state_in = macd_pkg::ST_SMAS_GO;
         macd_pkg::ST_SMAS_GO:   state_in = macd_pkg::ST_SMAS_WAIT;
         macd_pkg::ST_SMAS_WAIT: if (status.div_done) state_in = macd_pkg::ST_MUL;
         macd_pkg::ST_MUL:       state_in = macd_pkg::ST_EMAL_GO;
         macd_pkg::ST_EMAL_GO:   state_in = macd_pkg::ST_EMAL_WAIT;
         macd_pkg::ST_EMAL_WAIT: if (status.div_done) state_in = macd_pkg::ST_EMAS_GO;
         macd_pkg::ST_EMAS_GO:   state_in = macd_pkg::ST_EMAS_WAIT;
         macd_pkg::ST_EMAS_WAIT: if (status.div_done) state_in = macd_pkg::ST_EMIT;
         macd_pkg::ST_EMIT:      if (status.out_free) state_in = macd_pkg::ST_IDLE;
         default:                state_in = macd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.div_sel    = macd_pkg::DSEL_AVG;
      req_stall      = 1'b1;
      case (state_ff)
         macd_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.acc_en = req_valid;
         end
         macd_pkg::ST_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.sweep_clr = 1'b1;
         end
         macd_pkg::ST_SWEEP:   cmd.sweep_step = 1'b1;
         macd_pkg::ST_SMAL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = macd_pkg::DSEL_SMA_L;
         end
         macd_pkg::ST_SMAS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = macd_pkg::DSEL_SMA_S;
         end
         macd_pkg::ST_MUL:     cmd.mul_en = 1'b1;
         macd_pkg::ST_EMAL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = macd_pkg::DSEL_EMA_L;
         end
         macd_pkg::ST_EMAS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = macd_pkg::DSEL_EMA_S;
         end
         macd_pkg::ST_EMIT:    cmd.emit = status.out_free;
         default:              cmd.acc_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= macd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/macd_indicator_engine.sv */
// a closing order's result word waits on the shared radix-2 divider (average, two smas,
// two emas, 48 bits each) and the one-entry-per-cycle sweep of the history memory
// throughput: one order per cycle inside a period, input stalled during a period close
// reset: synchronous, active high; clears period state, config to defaults, history reads zero
// ---------------------------------------------------------------------------
// macd_indicator_engine
// macd over per-period average prices with configurable long and short windows
// ---------------------------------------------------------------------------
`default_nettype none

module macd_indicator_engine #(
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [macd_pkg::PRODUCT_W-1:0]  req_item_product,
   input  wire logic [macd_pkg::SIDE_W-1:0]     req_item_side,
   input  wire logic [macd_pkg::PRICE_W-1:0]    req_price,
   input  wire logic                            req_last_of_period,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [macd_pkg::MACD_W-1:0]   rsp_macd,
   output logic [macd_pkg::PRICE_W-1:0]         rsp_ema_long,
   output logic [macd_pkg::PRICE_W-1:0]         rsp_ema_short,
   output logic                                 rsp_ready_res,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [macd_pkg::ADDR_W-1:0]     paddr,
   input  wire logic [macd_pkg::DATA_W-1:0]     pwdata,
   output logic [macd_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);

   logic [macd_pkg::PRODUCT_W-1:0] product_ff, product_in;
   logic [macd_pkg::SIDE_W-1:0]    side_ff, side_in;
   logic [macd_pkg::WIN_W-1:0]     long_ff, long_in, short_ff, short_in;
   logic                           wr_en;
   logic [1:0]                     reg_idx;
   macd_pkg::cmd_type              cmd;
   macd_pkg::status_type           status;

   // register file write
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      product_in = product_ff;
      side_in    = side_ff;
      long_in    = long_ff;
      short_in   = short_ff;
      if (wr_en) begin
         case (reg_idx)
            macd_pkg::REG_PRODUCT: product_in = pwdata[macd_pkg::PRODUCT_W-1:0];
            macd_pkg::REG_SIDE:    side_in    = pwdata[macd_pkg::SIDE_W-1:0];
            macd_pkg::REG_LONG:    long_in    = pwdata[macd_pkg::WIN_W-1:0];
            macd_pkg::REG_SHORT:   short_in   = pwdata[macd_pkg::WIN_W-1:0];
            default:               product_in = product_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (reg_idx)
         macd_pkg::REG_PRODUCT: prdata = macd_pkg::DATA_W'(product_ff);
         macd_pkg::REG_SIDE:    prdata = macd_pkg::DATA_W'(side_ff);
         macd_pkg::REG_LONG:    prdata = macd_pkg::DATA_W'(long_ff);
         macd_pkg::REG_SHORT:   prdata = macd_pkg::DATA_W'(short_ff);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         product_ff <= '0;
         side_ff    <= '0;
         long_ff    <= 7'd26;
         short_ff   <= 7'd12;
      end else begin
         product_ff <= product_in;
         side_ff    <= side_in;
         long_ff    <= long_in;
         short_ff   <= short_in;
      end
   end

   macd_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_last_of_period (req_last_of_period),
      .req_stall          (req_stall),
      .status             (status),
      .cmd                (cmd)
   );

   macd_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .product_select (product_ff),
      .side_select    (side_ff),
      .long_period    (long_ff),
      .short_period   (short_ff),
      .item_product   (req_item_product),
      .item_side      (req_item_side),
      .price          (req_price),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_macd       (rsp_macd),
      .rsp_ema_long   (rsp_ema_long),
      .rsp_ema_short  (rsp_ema_short),
      .rsp_ready_res  (rsp_ready_res)
   );

endmodule

`default_nettype wire

/* test/macd_indicator_engine_tb.sv */
// ---------------------------------------------------------------------------
// macd_indicator_engine_tb
// drives order words grouped into periods through the engine, predicts each
// period-close word (both emas, their difference, readiness) with a local
// model of the averaging and ema math, and checks every result word in order
// across several product/side/window settings
// ---------------------------------------------------------------------------
`default_nettype none

module macd_indicator_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 64;
   localparam int CLOSE_LAT = 5 * 50 + 64 + 4;
   localparam int RX_HOLD   = 1500;

   typedef struct {
      logic [macd_pkg::PRODUCT_W-1:0] product;
      logic [macd_pkg::SIDE_W-1:0]    side;
      logic [macd_pkg::PRICE_W-1:0]   price;
      logic                           last;
   } order_type;

   typedef struct {
      logic [macd_pkg::MACD_W-1:0]  macd;
      logic [macd_pkg::PRICE_W-1:0] ema_long;
      logic [macd_pkg::PRICE_W-1:0] ema_short;
      logic                         ready;
   } macd_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [macd_pkg::PRODUCT_W-1:0] req_item_product = '0;
   logic [macd_pkg::SIDE_W-1:0] req_item_side = '0;
   logic [macd_pkg::PRICE_W-1:0] req_price = '0;
   logic req_last_of_period = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [macd_pkg::MACD_W-1:0] rsp_macd;
   logic [macd_pkg::PRICE_W-1:0] rsp_ema_long, rsp_ema_short;
   logic rsp_ready_res;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [macd_pkg::ADDR_W-1:0] paddr = '0;
   logic [macd_pkg::DATA_W-1:0] pwdata = '0;
   logic [macd_pkg::DATA_W-1:0] prdata;
   logic pready;

   macd_indicator_engine #(.HISTORY_DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_item_product(req_item_product), .req_item_side(req_item_side),
      .req_price(req_price), .req_last_of_period(req_last_of_period),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_macd(rsp_macd), .rsp_ema_long(rsp_ema_long),
      .rsp_ema_short(rsp_ema_short), .rsp_ready_res(rsp_ready_res),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [macd_pkg::PRODUCT_W-1:0] sel_product;
   logic [macd_pkg::SIDE_W-1:0]    sel_side;
   logic [macd_pkg::WIN_W-1:0]     win_long, win_short;
   logic [macd_pkg::SUM_W-1:0]     acc_sum;
   logic [macd_pkg::COUNT_W-1:0]   acc_count;
   logic [macd_pkg::PRICE_W-1:0]   avg_hist [DEPTH];
   int unsigned                    hist_ptr;
   int unsigned                    closes_seen;

   order_type     pending_orders[$];
   macd_word_type expected_words[$];
   int            errors = 0;
   bit            hold_rx = 0;

   function automatic int unsigned clamp_win(logic [macd_pkg::WIN_W-1:0] n);
      if (n < 2) return 2;
      if (n > DEPTH) return DEPTH;
      return n;
   endfunction

   function automatic logic [macd_pkg::PRICE_W-1:0] ema_over(logic [63:0] avg,
                                                             int unsigned n);
      logic [63:0] acc;
      logic [63:0] sma, num, den, q;
      acc = 0;
      for (int k = 1; k <= n; k++) acc += avg_hist[(hist_ptr + DEPTH - k) % DEPTH];
      sma = acc / n;
      num = 2 * avg + (n - 1) * sma;
      den = n + 1;
      q = (num + den / 2) / den;
      return q[macd_pkg::PRICE_W-1:0];
   endfunction

   // fold one accepted order into the predictor
   task automatic predict_order(order_type o);
      logic [63:0] avg;
      int unsigned nl, ns;
      macd_word_type w;
      if (o.product == sel_product && o.side == sel_side &&
          acc_count != macd_pkg::COUNT_MAX) begin
         acc_sum += o.price;
         acc_count++;
      end
      if (!o.last) return;
      avg = acc_count ? (64'(acc_sum) / acc_count) : 0;
      avg = avg & 64'hFFFF_FFFF;
      nl = clamp_win(win_long);
      ns = clamp_win(win_short);
      w.ema_long = ema_over(avg, nl);
      w.ema_short = ema_over(avg, ns);
      w.macd = {1'b0, w.ema_short} - {1'b0, w.ema_long};
      w.ready = (closes_seen >= nl);
      expected_words.push_back(w);
      avg_hist[hist_ptr] = avg[macd_pkg::PRICE_W-1:0];
      hist_ptr = (hist_ptr + 1) % DEPTH;
      if (closes_seen < 127) closes_seen++;
      acc_sum = '0;
      acc_count = '0;
   endtask

   // register write through setup and access cycles
   task automatic csr_write(logic [1:0] idx, logic [macd_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= macd_pkg::ADDR_W'(4 * idx); pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         macd_pkg::REG_PRODUCT: sel_product = value[macd_pkg::PRODUCT_W-1:0];
         macd_pkg::REG_SIDE:    sel_side = value[macd_pkg::SIDE_W-1:0];
         macd_pkg::REG_LONG:    win_long = value[macd_pkg::WIN_W-1:0];
         macd_pkg::REG_SHORT:   win_short = value[macd_pkg::WIN_W-1:0];
         default:               win_short = win_short;
      endcase
   endtask

   task automatic drain();
      while (pending_orders.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (CLOSE_LAT + 20) @(negedge clock);
   endtask

   // mostly matching orders, some noise
   task automatic queue_periods(int n_orders, int max_len);
      order_type o;
      int len, left;
      left = n_orders;
      while (left > 0) begin
         len = $urandom_range(1, max_len);
         for (int i = 0; i < len && left > 0; i++) begin
            if ($urandom_range(0, 9) < 7) begin
               o.product = sel_product; o.side = sel_side;
            end else begin
               o.product = $urandom_range(0, 3) == 0 ? 16'($urandom) : sel_product;
               o.side = 2'($urandom);
            end
            case ($urandom_range(0, 5))
               0: o.price = 32'hFFFF_FFFF;
               1: o.price = '0;
               default: o.price = $urandom;
            endcase
            o.last = (i == len - 1) || (left == 1);
            pending_orders.push_back(o);
            left--;
         end
      end
   endtask

   // acceptance sampled at the rising edge feeds the predictor
   logic accepted_q = 1'b0;
   always @(posedge clock) begin
      accepted_q <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         order_type o;
         o.product = req_item_product;
         o.side = req_item_side;
         o.price = req_price;
         o.last = req_last_of_period;
         predict_order(o);
      end
   end

   // driver: offers the next order, random gaps
   int gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_q) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_valid <= 1'b0;
            end else if (pending_orders.size() != 0) begin
               order_type o;
               o = pending_orders.pop_front();
               req_item_product <= o.product;
               req_item_side <= o.side;
               req_price <= o.price;
               req_last_of_period <= o.last;
               req_valid <= 1'b1;
               gap <= ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2)) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, one long hold on request
   int stall_left = 0;
   int hold_left = 0;
   bit hold_taken = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_rx && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= RX_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         macd_word_type e;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word macd=%h", $realtime, rsp_macd);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_macd !== e.macd) begin
               $display("%0t: macd expected %h actual %h", $realtime, e.macd, rsp_macd);
               errors++;
            end
            if (rsp_ema_long !== e.ema_long) begin
               $display("%0t: ema_long expected %h actual %h", $realtime,
                        e.ema_long, rsp_ema_long);
               errors++;
            end
            if (rsp_ema_short !== e.ema_short) begin
               $display("%0t: ema_short expected %h actual %h", $realtime,
                        e.ema_short, rsp_ema_short);
               errors++;
            end
            if (rsp_ready_res !== e.ready) begin
               $display("%0t: ready_res expected %b actual %b", $realtime,
                        e.ready, rsp_ready_res);
               errors++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #80ms;
      $display("macd_indicator_engine_tb: errors");
      $finish;
   end

   initial begin
      order_type o;
      sel_product = '0; sel_side = '0; win_long = 7'd26; win_short = 7'd12;
      acc_sum = '0; acc_count = '0; hist_ptr = 0; closes_seen = 0;
      foreach (avg_hist[i]) avg_hist[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, empty period, extremes, mismatched fields
      o = '{16'h0, 2'd0, 32'hFFFF_FFFF, 1'b1}; pending_orders.push_back(o);
      o = '{16'h1, 2'd0, 32'h1234_5678, 1'b1}; pending_orders.push_back(o);
      o = '{16'h0, 2'd3, 32'h1234_5678, 1'b0}; pending_orders.push_back(o);
      o = '{16'h0, 2'd0, 32'h0, 1'b0}; pending_orders.push_back(o);
      o = '{16'h0, 2'd0, 32'h8000_0001, 1'b1}; pending_orders.push_back(o);
      drain();
      csr_write(macd_pkg::REG_PRODUCT, 32'hFFFF);
      csr_write(macd_pkg::REG_SIDE, 32'h3);
      csr_write(macd_pkg::REG_LONG, 32'd64);
      csr_write(macd_pkg::REG_SHORT, 32'd2);
      o = '{16'hFFFF, 2'd3, 32'hFFFF_FFFF, 1'b0}; pending_orders.push_back(o);
      o = '{16'hFFFF, 2'd3, 32'hFFFF_FFFF, 1'b1}; pending_orders.push_back(o);
      o = '{16'hFFFE, 2'd2, 32'h5555_AAAA, 1'b1}; pending_orders.push_back(o);
      drain();
      // out-of-range windows clamp
      csr_write(macd_pkg::REG_LONG, 32'd0);
      csr_write(macd_pkg::REG_SHORT, 32'd127);
      queue_periods(12, 3);
      drain();

      // random phases through several settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(macd_pkg::REG_PRODUCT,
                   $urandom_range(0, 1) ? 32'($urandom_range(0, 65535)) : 0);
         csr_write(macd_pkg::REG_SIDE, $urandom_range(0, 3));
         case (ph)
            0: begin
               csr_write(macd_pkg::REG_LONG, 2); csr_write(macd_pkg::REG_SHORT, 2);
            end
            1: begin
               csr_write(macd_pkg::REG_LONG, 64); csr_write(macd_pkg::REG_SHORT, 64);
            end
            2: begin
               csr_write(macd_pkg::REG_LONG, 26); csr_write(macd_pkg::REG_SHORT, 12);
            end
            default: begin
               csr_write(macd_pkg::REG_LONG, $urandom_range(0, 127));
               csr_write(macd_pkg::REG_SHORT, $urandom_range(0, 127));
            end
         endcase
         if (ph == 2) begin
            // long receiver hold while orders keep coming
            hold_rx = 1;
            queue_periods(40, 2);
         end
         queue_periods(130, 6);
         drain();
      end

      if (errors == 0 && expected_words.size() == 0)
         $display("macd_indicator_engine_tb: clean");
      else
         $display("macd_indicator_engine_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
